### rtl/pzb_pkg.sv
// ----------------------------------------------------------------------------
// pzb_pkg
// Shared types, codes and helpers for the point z-buffer splatting block.
// ----------------------------------------------------------------------------
package pzb_pkg;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_FIT,
		ST_LOOK,
		ST_UPDATE
	} state_t;

	localparam logic CMD_SPLAT = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef enum logic [2:0] {
		REG_MIN_EDGE_X = 3'd0,
		REG_MIN_EDGE_Y = 3'd1,
		REG_STEP_X     = 3'd2,
		REG_STEP_Y     = 3'd3,
		REG_GRID_W     = 3'd4,
		REG_GRID_H     = 3'd5
	} reg_idx_t;

	localparam int QW      = 32;  // quotient and dividend width
	localparam int NW      = 13;  // wide enough for a grid size of 4096
	localparam int STEP_W  = 31;
	localparam int COLOR_W = 24;
	localparam logic [7:0] CH_MAX = 8'd255;

	// clip a signed channel to 0..255
	function automatic logic [7:0] sat8(input logic signed [15:0] v);
		logic [7:0] r;
		if (v[15])
			r = 8'd0;
		else if (v > 16'sd255)
			r = CH_MAX;
		else
			r = v[7:0];
		return r;
	endfunction

endpackage

### rtl/point_zbuffer_ortho_splat.sv
// ----------------------------------------------------------------------------
// point_zbuffer_ortho_splat
// Bins points into a raster grid and keeps the front-most point per cell.
// ----------------------------------------------------------------------------
// Use: raise start with a word on the input ports while busy is low; the word
// is taken at that edge. command 0 splats a point, command 1 reads a cell and
// clears it. Every word gives exactly one result, shown for one cycle with
// done high; the receiver cannot hold it off.
// Flow: a read goes through fit, RAM look-up and update before done; a
// splat first divides, one quotient bit per cycle from the two restoring
// dividers (x and y run side by side). A word outside the grid skips the
// look-up. busy is high from accept until the result is registered, so one
// word is in flight at a time. A new word may be taken in the done cycle.
// Cell state is one 57-bit synchronous RAM (valid, depth, colour) with a
// registered read; each word does at most one read and at most one write-back.
// Reset: configuration and control registers return to their defaults and a
// clearing pass writes every RAM entry empty, all 2**(row bits + column bits)
// of them (65536 by default), with busy high. A configuration write lands at
// the edge it is presented on; make writes only while no word is in flight.
// ----------------------------------------------------------------------------
module point_zbuffer_ortho_splat
	import pzb_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr,
	input  logic [2:0]          cfg_idx,
	input  logic [31:0]         cfg_data,
	input  logic                start,
	output logic                busy,
	input  logic                command,
	input  logic signed [31:0]  point_x,
	input  logic signed [31:0]  point_y,
	input  logic signed [31:0]  point_depth,
	input  logic signed [15:0]  red,
	input  logic signed [15:0]  green,
	input  logic signed [15:0]  blue,
	input  logic [7:0]          cell_row,
	input  logic [7:0]          cell_col,
	output logic                done,
	output logic                landed,
	output logic                cell_valid,
	output logic [7:0]          cell_red,
	output logic [7:0]          cell_green,
	output logic [7:0]          cell_blue
);

	localparam int CW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
	localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int AW    = RW + CW;
	localparam int DEPTH = 2 ** AW;
	localparam int WW    = 1 + QW + COLOR_W;
	localparam logic [NW-1:0] MW_N = NW'(MAX_WIDTH);
	localparam logic [NW-1:0] MH_N = NW'(MAX_HEIGHT);

	// configuration
	logic signed [31:0] edge_x_q, edge_y_q;
	logic [STEP_W-1:0]  step_x_q, step_y_q;
	logic [8:0]         grid_w_q, grid_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_x_q <= '0;
			edge_y_q <= '0;
			step_x_q <= STEP_W'(65536);
			step_y_q <= STEP_W'(65536);
			grid_w_q <= 9'd256;
			grid_h_q <= 9'd256;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_MIN_EDGE_X: edge_x_q <= cfg_data;
				REG_MIN_EDGE_Y: edge_y_q <= cfg_data;
				REG_STEP_X:     step_x_q <= cfg_data[STEP_W-1:0];
				REG_STEP_Y:     step_y_q <= cfg_data[STEP_W-1:0];
				REG_GRID_W:     grid_w_q <= cfg_data[8:0];
				REG_GRID_H:     grid_h_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// control
	state_t state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [4:0]    cnt_q;
	logic          accept;
	logic          fit_ok;
	logic [AW-1:0] fit_addr;

	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE:   if (accept) state_d = (command == CMD_READ) ? ST_FIT : ST_DIV;
			ST_DIV:    if (cnt_q == 5'd31) state_d = ST_FIT;
			ST_FIT:    state_d = fit_ok ? ST_LOOK : ST_UPDATE;
			ST_LOOK:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (state_q == ST_DIV)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

	// captured word
	logic                cmd_q;
	logic signed [31:0]  z_q;
	logic [COLOR_W-1:0]  rgb_q;
	logic [7:0]          row_in_q, col_in_q;
	logic                negx_q, negy_q;
	logic [QW-1:0]       remx_q, remy_q, quox_q, quoy_q;
	logic [STEP_W-1:0]   sx_q, sy_q;
	logic signed [32:0]  dx, dy;
	logic [QW:0]         tx, ty;
	logic                gex, gey;

	assign dx = 33'(point_x) - 33'(edge_x_q);
	assign dy = 33'(point_y) - 33'(edge_y_q);

	// one restoring step per axis: bring down the next dividend bit
	assign tx  = {remx_q, quox_q[QW-1]};
	assign ty  = {remy_q, quoy_q[QW-1]};
	assign gex = tx >= (QW+1)'(sx_q);
	assign gey = ty >= (QW+1)'(sy_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= command;
			z_q      <= point_depth;
			rgb_q    <= {sat8(red), sat8(green), sat8(blue)};
			row_in_q <= cell_row;
			col_in_q <= cell_col;
			negx_q   <= dx[32];
			negy_q   <= dy[32];
			// floor of a negative quotient is never inside, so divide |d|-1 there
			quox_q   <= dx[32] ? ~dx[QW-1:0] : dx[QW-1:0];
			quoy_q   <= dy[32] ? ~dy[QW-1:0] : dy[QW-1:0];
			remx_q   <= '0;
			remy_q   <= '0;
			sx_q     <= (step_x_q == '0) ? STEP_W'(1) : step_x_q;
			sy_q     <= (step_y_q == '0) ? STEP_W'(1) : step_y_q;
		end else if (state_q == ST_DIV) begin
			remx_q <= gex ? QW'(tx - (QW+1)'(sx_q)) : tx[QW-1:0];
			remy_q <= gey ? QW'(ty - (QW+1)'(sy_q)) : ty[QW-1:0];
			quox_q <= {quox_q[QW-2:0], gex};
			quoy_q <= {quoy_q[QW-2:0], gey};
		end
	end

	// bounds and address
	logic [NW-1:0] nx, ny, cx, cy, rr, rc;
	logic          inx, iny, rd_ok;

	always_comb begin
		nx = (NW'(grid_w_q) > MW_N) ? MW_N : NW'(grid_w_q);
		ny = (NW'(grid_h_q) > MH_N) ? MH_N : NW'(grid_h_q);
		inx = !negx_q && (nx != '0) && (quox_q <= QW'(nx));
		iny = !negy_q && (ny != '0) && (quoy_q <= QW'(ny));
		// an index equal to the size lands in the last cell
		cx = (quox_q == QW'(nx)) ? nx - 1'b1 : quox_q[NW-1:0];
		cy = (quoy_q == QW'(ny)) ? ny - 1'b1 : quoy_q[NW-1:0];
		rr = NW'(row_in_q);
		rc = NW'(col_in_q);
		rd_ok = (rr < MH_N) && (rc < MW_N);
		if (cmd_q == CMD_READ) begin
			fit_ok   = rd_ok;
			fit_addr = {rr[RW-1:0], rc[CW-1:0]};
		end else begin
			fit_ok   = inx && iny;
			fit_addr = {cy[RW-1:0], cx[CW-1:0]};
		end
	end

	logic          ok_q;
	logic [AW-1:0] addr_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_FIT) begin
			ok_q   <= fit_ok;
			addr_q <= fit_addr;
		end
	end

	// cell RAM: {valid, depth, colour}
	logic [WW-1:0] mem [DEPTH];
	logic [WW-1:0] rd_data;
	logic [WW-1:0] wr_data;
	logic [AW-1:0] wr_addr;
	logic          wr_en;
	logic          hit, win;

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK)
			rd_data <= mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	assign hit = rd_data[WW-1];
	assign win = !hit || (z_q >= $signed(rd_data[WW-2:COLOR_W]));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = {1'b0, rd_data[WW-2:0]};
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (state_q == ST_UPDATE && ok_q) begin
			if (cmd_q == CMD_READ) begin
				wr_en = 1'b1;  // drop the cell once read
			end else if (win) begin
				wr_en   = 1'b1;
				wr_data = {1'b1, z_q, rgb_q};
			end
		end
	end

	// result register
	logic               done_q, landed_q, valid_q;
	logic [COLOR_W-1:0] color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= (state_q == ST_UPDATE);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			landed_q <= (cmd_q == CMD_SPLAT) && ok_q;
			valid_q  <= (cmd_q == CMD_READ) && ok_q && hit;
			color_q  <= ((cmd_q == CMD_READ) && ok_q && hit) ?
				rd_data[COLOR_W-1:0] : '0;
		end
	end

	assign done       = done_q;
	assign landed     = landed_q;
	assign cell_valid = valid_q;
	assign cell_red   = color_q[23:16];
	assign cell_green = color_q[15:8];
	assign cell_blue  = color_q[7:0];

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for more than one cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("busy low after accepting a word");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(landed && cell_valid)) else $error("splat and read result mixed");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !wr_en) else $error("RAM written while idle");

endmodule
